// ===== hdl/swfc_pkg.sv =====
// shared constants, types and a helper function for the sync word frame capture block
`timescale 1ns / 1ps
`default_nettype none
package swfc_pkg;

  localparam int SYNC_BITS        = 32;
  localparam int MAX_PACKET_BYTES = 255;

  localparam int CNT_W  = $clog2(SYNC_BITS + 1);
  localparam int FILL_W = $clog2(SYNC_BITS + 1);
  localparam int ERR_W  = 6;
  localparam int CMP_W  = (CNT_W > ERR_W) ? CNT_W : ERR_W;
  localparam int REP_W  = $clog2(2 * SYNC_BITS + 1);

  localparam int BCNT_W = $clog2(8 * MAX_PACKET_BYTES + 1);
  localparam int NIDX_W = BCNT_W - 3;
  localparam int LEN_W  = (NIDX_W + 1 > 8) ? NIDX_W + 1 : 8;

  localparam int POS_W  = 48;
  localparam int SEQ_W  = 32;
  localparam int ADDR_W = 4;

  localparam logic [31:0]      SYNC_PATTERN_RST = 32'h5DE6_2A7E;
  localparam logic             BIT_REV_RST      = 1'b0;
  localparam logic [ERR_W-1:0] MAX_ERR_RST      = 6'd1;
  localparam logic [7:0]       PKT_BYTES_RST    = 8'd255;

  typedef enum logic [1:0] {
    REG_SYNC_PATTERN = 2'd0,
    REG_BIT_REV      = 2'd1,
    REG_MAX_ERRORS   = 2'd2,
    REG_PKT_BYTES    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic replaying;
    logic sync_hit;
  } corr_status_t;

  typedef struct packed {
    logic capturing;
    logic byte_due;
    logic emit_last;
  } cap_status_t;

  // flip bit order inside every byte
  function automatic logic [31:0] rev_bytes(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      for (int k = 0; k < 8; k++) begin
        r[8*b + 7 - k] = v[8*b + k];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/swfc_if.sv =====
// word channel interfaces for received bits and captured bytes
`timescale 1ns / 1ps
`default_nettype none
interface swfc_in_if;
  logic valid;
  logic ready;
  logic rx_bit;
  modport source (output valid, output rx_bit, input ready);
  modport sink   (input valid, input rx_bit, output ready);
endinterface

interface swfc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packet_byte;
  logic [7:0]  byte_index;
  logic        last_byte;
  logic [31:0] sequence_number;
  logic [47:0] payload_offset;
  modport source (output valid, output packet_byte, output byte_index, output last_byte,
                  output sequence_number, output payload_offset, input ready);
  modport sink   (input valid, input packet_byte, input byte_index, input last_byte,
                  input sequence_number, input payload_offset, output ready);
endinterface
`default_nettype wire

// ===== hdl/swfc_cell.sv =====
// one correlator cell: holds a partial mismatch count and passes it down the chain
`timescale 1ns / 1ps
`default_nettype none
module swfc_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      din,
  input  logic                      pat_bit,
  input  logic [swfc_pkg::CNT_W-1:0] acc_in,
  output logic [swfc_pkg::CNT_W-1:0] acc_nxt,
  output logic [swfc_pkg::CNT_W-1:0] acc_r
);
  import swfc_pkg::*;

  assign acc_nxt = acc_in + CNT_W'(din ^ pat_bit);

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/swfc_corr.sv =====
// sync word correlator: chain of mismatch cells, bit window, fill count and reload pass
`timescale 1ns / 1ps
`default_nettype none
module swfc_corr (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       din,
  input  swfc_pkg::cap_status_t      cap_st,
  input  logic [31:0]                pattern,
  input  logic                       bit_rev,
  input  logic [swfc_pkg::ERR_W-1:0] max_err,
  input  logic                       pat_wr,
  output swfc_pkg::corr_status_t     st
);
  import swfc_pkg::*;

  logic [SYNC_BITS-1:0] pat;
  logic [SYNC_BITS-1:0] win_r;
  logic [FILL_W-1:0]    fill_r;
  logic [REP_W-1:0]     rep_r;
  logic [REP_W-1:0]     rep_nxt;
  logic                 replaying;
  logic                 feed_bit;
  logic                 feed_en;
  logic                 restart;
  logic                 searching;

  logic [CNT_W-1:0] acc_in  [SYNC_BITS];
  logic [CNT_W-1:0] acc_nxt [SYNC_BITS];
  logic [CNT_W-1:0] acc_r   [SYNC_BITS];

  assign pat       = bit_rev ? SYNC_BITS'(rev_bytes(pattern)) : SYNC_BITS'(pattern);
  assign replaying = (rep_r != '0);
  assign searching = !cap_st.capturing;
  assign restart   = step && cap_st.emit_last;

  // during a reload pass the window rotates through the chain, oldest bit first
  assign feed_bit = replaying ? win_r[SYNC_BITS-1] : din;
  assign feed_en  = step || replaying;

  // cell k sees pattern bit k; cell 0 ends up with the whole window's distance
  for (genvar k = 0; k < SYNC_BITS; k++) begin : g_cell
    if (k == SYNC_BITS - 1) begin : g_end
      assign acc_in[k] = '0;
    end else begin : g_mid
      assign acc_in[k] = acc_r[k+1];
    end
    swfc_cell u_cell (
      .clk     (clk),
      .en      (feed_en),
      .din     (feed_bit),
      .pat_bit (pat[k]),
      .acc_in  (acc_in[k]),
      .acc_nxt (acc_nxt[k]),
      .acc_r   (acc_r[k])
    );
  end

  assign st.replaying = replaying;
  assign st.sync_hit  = step && searching && (fill_r >= FILL_W'(SYNC_BITS - 1))
                        && (CMP_W'(acc_nxt[0]) <= CMP_W'(max_err));

  // a new write during a pass extends it so the rotation stays a whole turn
  always_comb begin
    rep_nxt = replaying ? rep_r - 1'b1 : '0;
    if (pat_wr) begin
      rep_nxt = rep_nxt + REP_W'(SYNC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      rep_r  <= '0;
    end else begin
      rep_r <= rep_nxt;
      if (restart) begin
        win_r  <= '0;
        fill_r <= '0;
      end else if (replaying) begin
        win_r <= {win_r[SYNC_BITS-2:0], win_r[SYNC_BITS-1]};
      end else if (step && searching) begin
        win_r <= {win_r[SYNC_BITS-2:0], din};
        if (fill_r < FILL_W'(SYNC_BITS)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/swfc_capture.sv =====
// payload capture: byte packing, packet counters and the output register
`timescale 1ns / 1ps
`default_nettype none
module swfc_capture (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  din,
  input  logic                  sync_hit,
  input  logic [7:0]            len_cfg,
  output swfc_pkg::cap_status_t st,
  swfc_out_if.source            out_ch
);
  import swfc_pkg::*;

  logic              capturing_r;
  logic [BCNT_W-1:0] cnt_r;
  logic [7:0]        byte_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  start_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [7:0]        out_idx_r;
  logic              out_last_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [POS_W-1:0]  out_start_r;

  logic              byte_due;
  logic              emit;
  logic              last;
  logic [NIDX_W-1:0] idx;
  logic [LEN_W-1:0]  pb_ext;
  logic [LEN_W-1:0]  len;

  assign byte_due = capturing_r && (cnt_r[2:0] == 3'b111);
  assign emit     = step && byte_due;
  assign idx      = cnt_r[BCNT_W-1:3];

  // zero length counts as one, long lengths clamp to MAX_PACKET_BYTES
  assign pb_ext = LEN_W'(len_cfg);
  always_comb begin
    priority if (pb_ext == '0) begin
      len = LEN_W'(1);
    end else if (pb_ext > LEN_W'(MAX_PACKET_BYTES)) begin
      len = LEN_W'(MAX_PACKET_BYTES);
    end else begin
      len = pb_ext;
    end
  end
  assign last = (LEN_W'(idx) + 1'b1) >= len;

  assign st.capturing = capturing_r;
  assign st.byte_due  = byte_due;
  assign st.emit_last = byte_due && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        pos_r <= pos_r + 1'b1;
        if (capturing_r) begin
          cnt_r <= cnt_r + 1'b1;
          if (byte_due && last) begin
            capturing_r <= 1'b0;
            cnt_r       <= '0;
            seq_r       <= seq_r + 1'b1;
          end
        end else if (sync_hit) begin
          capturing_r <= 1'b1;
          cnt_r       <= '0;
          start_r     <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && capturing_r) begin
      byte_r <= {byte_r[6:0], din};
    end
    if (emit) begin
      out_byte_r  <= {byte_r[6:0], din};
      out_idx_r   <= 8'(idx);
      out_last_r  <= last;
      out_seq_r   <= seq_r;
      out_start_r <= start_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.packet_byte     = out_byte_r;
  assign out_ch.byte_index      = out_idx_r;
  assign out_ch.last_byte       = out_last_r;
  assign out_ch.sequence_number = out_seq_r;
  assign out_ch.payload_offset  = out_start_r;

endmodule
`default_nettype wire

// ===== hdl/sync_word_frame_capture_top.sv =====
// sync word frame capture: one bit per cycle in while ready is high, captured payload bytes out, register port
// timing: sync is decided in the cycle that accepts the last sync bit; a payload byte is
//   presented right after the edge that accepts its eighth bit and stays valid until ready takes it
// throughput: one bit per cycle while ready is high, set by the chain of correlator cells (one cell per sync bit)
// a write to the sync pattern or bit order holds ready low while the window
//   is run through the cell chain again to rebuild the partial counts
// synchronous active-low reset clears counters, window and output valid, registers go to defaults
`timescale 1ns / 1ps
`default_nettype none
module sync_word_frame_capture_top (
  input  logic                        clk,
  input  logic                        rst_n,
  swfc_in_if.sink                     in_ch,
  swfc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import swfc_pkg::*;

  logic [31:0]      sync_pattern_r;
  logic             bit_rev_r;
  logic [ERR_W-1:0] max_err_r;
  logic [7:0]       pkt_bytes_r;

  logic         cfg_wr;
  logic         pat_wr;
  cfg_reg_t     reg_sel;
  logic         step;
  corr_status_t cst;
  cap_status_t  kst;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pat_wr  = cfg_wr && ((reg_sel == REG_SYNC_PATTERN) || (reg_sel == REG_BIT_REV));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= SYNC_PATTERN_RST;
      bit_rev_r      <= BIT_REV_RST;
      max_err_r      <= MAX_ERR_RST;
      pkt_bytes_r    <= PKT_BYTES_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SYNC_PATTERN: sync_pattern_r <= pwdata;
        REG_BIT_REV:      bit_rev_r      <= pwdata[0];
        REG_MAX_ERRORS:   max_err_r      <= pwdata[ERR_W-1:0];
        REG_PKT_BYTES:    pkt_bytes_r    <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYNC_PATTERN: prdata = sync_pattern_r;
      REG_BIT_REV:      prdata = 32'(bit_rev_r);
      REG_MAX_ERRORS:   prdata = 32'(max_err_r);
      REG_PKT_BYTES:    prdata = 32'(pkt_bytes_r);
      default:          prdata = '0;
    endcase
  end

  // hold off a bit during a reload pass, or when it would finish a byte while the output word is still unread
  assign in_ch.ready = !cst.replaying && !(kst.byte_due && out_ch.valid && !out_ch.ready);
  assign step        = in_ch.valid && in_ch.ready;

  swfc_corr u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .din     (in_ch.rx_bit),
    .cap_st  (kst),
    .pattern (sync_pattern_r),
    .bit_rev (bit_rev_r),
    .max_err (max_err_r),
    .pat_wr  (pat_wr),
    .st      (cst)
  );

  swfc_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .din      (in_ch.rx_bit),
    .sync_hit (cst.sync_hit),
    .len_cfg  (pkt_bytes_r),
    .st       (kst),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  a_sync_starts_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cst.sync_hit |=> kst.capturing)
    else $error("sync hit did not start payload capture");

  a_last_ends_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kst.emit_last) |=> (!kst.capturing && out_ch.last_byte))
    else $error("last byte did not return to search");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kst.byte_due) |-> (!out_ch.valid || out_ch.ready))
    else $error("byte completed while output word unread");

  a_no_search_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    kst.capturing |-> !cst.sync_hit)
    else $error("sync hit raised during capture");
`endif

endmodule
`default_nettype wire
